@@ rtl/core/lcdn_pkg.sv @@
// Shared types, codes and constants for the character LCD nibble interface.
package lcdn_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 8;

  typedef enum logic [1:0] {
    FN_TICK   = 2'd0,
    FN_DATA   = 2'd1,
    FN_CMD    = 2'd2,
    FN_CURSOR = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    PH_WAIT  = 2'd0,
    PH_EHIGH = 2'd1,
    PH_ELOW  = 2'd2,
    PH_IDLE  = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_UP     = 3'd0,
    CFG_FIRST_GAP    = 3'd1,
    CFG_SECOND_GAP   = 3'd2,
    CFG_ENABLE_HIGH  = 3'd3,
    CFG_ENABLE_LOW   = 3'd4,
    CFG_FUNCTION_SET = 3'd5,
    CFG_DISPLAY_CTRL = 3'd6,
    CFG_ENTRY_MODE   = 3'd7
  } cfg_idx_e;

  localparam logic [3:0] STEP_POWER_UP  = 4'd0;
  localparam logic [3:0] STEP_NIB3_A    = 4'd1;
  localparam logic [3:0] STEP_GAP_A     = 4'd2;
  localparam logic [3:0] STEP_NIB3_B    = 4'd3;
  localparam logic [3:0] STEP_GAP_B     = 4'd4;
  localparam logic [3:0] STEP_NIB3_C    = 4'd5;
  localparam logic [3:0] STEP_NIB2      = 4'd6;
  localparam logic [3:0] STEP_FUNC_SET  = 4'd7;
  localparam logic [3:0] STEP_DISP_CTRL = 4'd8;
  localparam logic [3:0] STEP_CLEAR     = 4'd9;
  localparam logic [3:0] STEP_ENTRY     = 4'd10;
  localparam logic [3:0] STEP_DONE      = 4'd11;

  localparam logic [3:0] NIBBLE_INIT  = 4'h3;
  localparam logic [3:0] NIBBLE_4BIT  = 4'h2;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_DDRAM    = 8'h80;
  localparam logic [7:0] TICK_MAX     = 8'hFF;

  localparam logic [7:0] RST_POWER_UP     = 8'd20;
  localparam logic [7:0] RST_FIRST_GAP    = 8'd5;
  localparam logic [7:0] RST_SECOND_GAP   = 8'd1;
  localparam logic [7:0] RST_ENABLE_HIGH  = 8'd1;
  localparam logic [7:0] RST_ENABLE_LOW   = 8'd1;
  localparam logic [7:0] RST_FUNCTION_SET = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CTRL = 8'h0C;
  localparam logic [7:0] RST_ENTRY_MODE   = 8'h06;

  typedef struct packed {
    logic [7:0] power_up_ticks;
    logic [7:0] first_gap_ticks;
    logic [7:0] second_gap_ticks;
    logic [7:0] enable_high_ticks;
    logic [7:0] enable_low_ticks;
    logic [7:0] function_set_command;
    logic [7:0] display_control_command;
    logic [7:0] entry_mode_command;
  } cfg_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
    logic       cursor_row;
    logic [5:0] cursor_col;
  } item_t;

  typedef struct packed {
    logic       pin_rs;
    logic       pin_enable;
    logic [3:0] pin_data;
    logic       ready_res;
    logic       rejected;
  } res_t;

endpackage

@@ rtl/core/lcdn_cfg_regs.sv @@
// Configuration register file for timing lengths and init commands.
module lcdn_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lcdn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcdn_pkg::CfgW-1:0]    cfg_wdata_i,
  output lcdn_pkg::cfg_t               cfg_o
);
  import lcdn_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POWER_UP:     cfg_d.power_up_ticks          = cfg_wdata_i;
        CFG_FIRST_GAP:    cfg_d.first_gap_ticks         = cfg_wdata_i;
        CFG_SECOND_GAP:   cfg_d.second_gap_ticks        = cfg_wdata_i;
        CFG_ENABLE_HIGH:  cfg_d.enable_high_ticks       = cfg_wdata_i;
        CFG_ENABLE_LOW:   cfg_d.enable_low_ticks        = cfg_wdata_i;
        CFG_FUNCTION_SET: cfg_d.function_set_command    = cfg_wdata_i;
        CFG_DISPLAY_CTRL: cfg_d.display_control_command = cfg_wdata_i;
        CFG_ENTRY_MODE:   cfg_d.entry_mode_command      = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_up_ticks          <= RST_POWER_UP;
      cfg_q.first_gap_ticks         <= RST_FIRST_GAP;
      cfg_q.second_gap_ticks        <= RST_SECOND_GAP;
      cfg_q.enable_high_ticks       <= RST_ENABLE_HIGH;
      cfg_q.enable_low_ticks        <= RST_ENABLE_LOW;
      cfg_q.function_set_command    <= RST_FUNCTION_SET;
      cfg_q.display_control_command <= RST_DISPLAY_CTRL;
      cfg_q.entry_mode_command      <= RST_ENTRY_MODE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/lcdn_ctrl.sv @@
// Sequencer state and the single-pass update applied for each request.
module lcdn_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  lcdn_pkg::item_t item_i,
  input  lcdn_pkg::cfg_t  cfg_i,
  output lcdn_pkg::res_t  res_o
);
  import lcdn_pkg::*;

  phase_e     phase_q, phase_d;
  logic [3:0] step_q, step_d;
  logic [7:0] tick_q, tick_d;
  logic [7:0] pending_q, pending_d;
  logic       low_next_q, low_next_d;
  logic       rs_q, rs_d;
  logic       en_q, en_d;
  logic [3:0] data_q, data_d;

  logic [7:0] phase_len;
  logic [7:0] tick_inc;
  logic [3:0] step_n;
  logic       unit_go;
  logic       byte_go;
  logic [7:0] byte_val;
  logic       nib_go;
  logic [3:0] nib_val;
  logic       rej;

  always_comb begin
    priority if (phase_q == PH_EHIGH) begin
      phase_len = cfg_i.enable_high_ticks;
    end else if (phase_q == PH_ELOW) begin
      phase_len = cfg_i.enable_low_ticks;
    end else if (step_q == STEP_POWER_UP) begin
      phase_len = cfg_i.power_up_ticks;
    end else if (step_q == STEP_GAP_A) begin
      phase_len = cfg_i.first_gap_ticks;
    end else begin
      phase_len = cfg_i.second_gap_ticks;
    end
  end

  assign tick_inc = (tick_q != TICK_MAX) ? tick_q + 8'd1 : tick_q;
  assign step_n   = step_q + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    tick_d     = tick_q;
    pending_d  = pending_q;
    low_next_d = low_next_q;
    rs_d       = rs_q;
    en_d       = en_q;
    data_d     = data_q;
    unit_go    = 1'b0;
    byte_go    = 1'b0;
    byte_val   = pending_q;
    nib_go     = 1'b0;
    nib_val    = data_q;
    rej        = 1'b0;

    if (func_e'(item_i.func) == FN_TICK) begin
      if (phase_q != PH_IDLE) begin
        tick_d = tick_inc;
        if (tick_inc >= phase_len) begin
          unique case (phase_q)
            PH_EHIGH: begin
              en_d    = 1'b0;
              phase_d = PH_ELOW;
              tick_d  = '0;
            end
            PH_ELOW: begin
              if (low_next_q) begin
                low_next_d = 1'b0;
                nib_go     = 1'b1;
                nib_val    = pending_q[3:0];
              end else begin
                unit_go = 1'b1;
              end
            end
            default: unit_go = 1'b1;
          endcase
        end
      end
    end else if (phase_q != PH_IDLE) begin
      rej = 1'b1;
    end else begin
      byte_go = 1'b1;
      unique case (func_e'(item_i.func))
        FN_DATA: begin
          rs_d     = 1'b1;
          byte_val = item_i.data_byte;
        end
        FN_CMD: begin
          rs_d     = 1'b0;
          byte_val = item_i.data_byte;
        end
        default: begin
          rs_d     = 1'b0;
          byte_val = CMD_DDRAM | {1'b0, item_i.cursor_row, item_i.cursor_col};
        end
      endcase
    end

    if (unit_go) begin
      if (step_q < STEP_DONE) begin
        step_d = step_n;
        rs_d   = 1'b0;
        unique case (step_n)
          STEP_NIB3_A, STEP_NIB3_B, STEP_NIB3_C: begin
            nib_go  = 1'b1;
            nib_val = NIBBLE_INIT;
          end
          STEP_GAP_A, STEP_GAP_B: begin
            en_d    = 1'b0;
            phase_d = PH_WAIT;
            tick_d  = '0;
          end
          STEP_NIB2: begin
            nib_go  = 1'b1;
            nib_val = NIBBLE_4BIT;
          end
          STEP_FUNC_SET: begin
            byte_go  = 1'b1;
            byte_val = cfg_i.function_set_command;
          end
          STEP_DISP_CTRL: begin
            byte_go  = 1'b1;
            byte_val = cfg_i.display_control_command;
          end
          STEP_CLEAR: begin
            byte_go  = 1'b1;
            byte_val = CMD_CLEAR;
          end
          STEP_ENTRY: begin
            byte_go  = 1'b1;
            byte_val = cfg_i.entry_mode_command;
          end
          default: begin
            phase_d = PH_IDLE;
            tick_d  = '0;
          end
        endcase
      end else begin
        phase_d = PH_IDLE;
        tick_d  = '0;
      end
    end

    if (byte_go) begin
      pending_d  = byte_val;
      low_next_d = 1'b1;
      nib_go     = 1'b1;
      nib_val    = byte_val[7:4];
    end

    if (nib_go) begin
      data_d  = nib_val;
      en_d    = 1'b1;
      phase_d = PH_EHIGH;
      tick_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      step_q     <= STEP_POWER_UP;
      tick_q     <= '0;
      pending_q  <= '0;
      low_next_q <= 1'b0;
      rs_q       <= 1'b0;
      en_q       <= 1'b0;
      data_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      step_q     <= step_d;
      tick_q     <= tick_d;
      pending_q  <= pending_d;
      low_next_q <= low_next_d;
      rs_q       <= rs_d;
      en_q       <= en_d;
      data_q     <= data_d;
    end
  end

  always_comb begin
    res_o.pin_rs     = rs_d;
    res_o.pin_enable = en_d;
    res_o.pin_data   = data_d;
    res_o.ready_res  = (phase_d == PH_IDLE);
    res_o.rejected   = rej;
  end

endmodule

@@ rtl/core/char_lcd_nibble_interface.sv @@
// Top level of the character LCD nibble interface with request and result registers.
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid_i / in_stall_o   func, data_byte, cursor_row, cursor_col
//   out      output     out_valid_o / out_stall_i pin_rs, pin_enable, pin_data, ready_res,
//                                                 rejected
//   cfg      input      cfg_we_i                 cfg_index_i, cfg_wdata_i
//
// A request is taken every cycle while in_stall_o is low; its result reaches the outputs
// when the result register takes it from the request register.
// Reset clears the sequencer to the power-up wait and loads default register values.
// A stall on the output holds a full result register and, once the request register is
// also full, raises in_stall_o in the same cycle.
module char_lcd_nibble_interface (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   in_func_i,
  input  logic [7:0]                   in_data_byte_i,
  input  logic                         in_cursor_row_i,
  input  logic [5:0]                   in_cursor_col_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_pin_rs_o,
  output logic                         out_pin_enable_o,
  output logic [3:0]                   out_pin_data_o,
  output logic                         out_ready_res_o,
  output logic                         out_rejected_o,
  input  logic                         cfg_we_i,
  input  logic [lcdn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lcdn_pkg::CfgW-1:0]    cfg_wdata_i
);
  import lcdn_pkg::*;

  cfg_t  cfg;
  item_t req_q;
  logic  req_valid_q;
  res_t  res_d;
  res_t  res_q;
  logic  res_valid_q;
  logic  res_adv;
  logic  req_take;
  logic  step;

  assign res_adv    = !res_valid_q || !out_stall_i;
  assign step       = req_valid_q && res_adv;
  assign in_stall_o = req_valid_q && !res_adv;
  assign req_take   = in_valid_i && !in_stall_o;

  lcdn_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcdn_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (req_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (req_take) begin
        req_valid_q <= 1'b1;
      end else if (step) begin
        req_valid_q <= 1'b0;
      end
      if (res_adv) begin
        res_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q.func       <= in_func_i;
      req_q.data_byte  <= in_data_byte_i;
      req_q.cursor_row <= in_cursor_row_i;
      req_q.cursor_col <= in_cursor_col_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = res_valid_q;
  assign out_pin_rs_o     = res_q.pin_rs;
  assign out_pin_enable_o = res_q.pin_enable;
  assign out_pin_data_o   = res_q.pin_data;
  assign out_ready_res_o  = res_q.ready_res;
  assign out_rejected_o   = res_q.rejected;

  a_reject_not_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rejected_o |-> !out_ready_res_o)
    else $error("Rejected request reported with the controller ready.");

  a_idle_enable_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_res_o |-> !out_pin_enable_o)
    else $error("Enable line high while the controller reports ready.");

  a_no_stall_free_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("Input stalled although the result register can advance.");

  a_result_follows_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_o)
    else $error("Processed request produced no result.");

endmodule
